// ===== rtl/bskf_pkg.sv =====
// bskf_pkg: shared types, constants and the step program of the soc kalman filter
// no dependencies; imported by the top level of the filter
package bskf_pkg;

  // default word format, signed q16.32 in 48 bits
  localparam int unsigned WORD_BITS_DEF = 48;
  localparam int unsigned FRAC_BITS_DEF = 32;

  // configuration port
  localparam int unsigned CFG_BITS     = 41;
  localparam int unsigned CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_INITIAL_SOC       = 3'd0,
    REG_CHARGE_STEP       = 3'd1,
    REG_DECAY_FACTOR      = 3'd2,
    REG_RC_GAIN           = 3'd3,
    REG_SERIES_RESISTANCE = 3'd4,
    REG_SOC_PROCESS_NOISE = 3'd5,
    REG_RC_PROCESS_NOISE  = 3'd6,
    REG_MEASUREMENT_NOISE = 3'd7
  } cfg_reg_t;

  // channel payloads
  typedef struct packed {
    logic signed [31:0] cell_current;
    logic signed [31:0] cell_voltage;
  } in_item_t;

  typedef struct packed {
    logic [32:0]        soc_estimate;
    logic signed [47:0] rc_voltage;
    logic signed [47:0] innovation;
  } out_item_t;

  // shared arithmetic unit operations
  typedef enum logic [2:0] {
    ALU_ADD   = 3'd0,
    ALU_SUB   = 3'd1,
    ALU_CLAMP = 3'd2,
    ALU_MUL   = 3'd3,
    ALU_DIV   = 3'd4
  } alu_op_t;

  // operand codes: codes below 16 live in the scratch memory
  typedef enum logic [5:0] {
    O_T0    = 6'd0,
    O_T1    = 6'd1,
    O_SOCP  = 6'd2,
    O_VRCP  = 6'd3,
    O_P00   = 6'd4,
    O_P01   = 6'd5,
    O_P10   = 6'd6,
    O_P11   = 6'd7,
    O_S     = 6'd8,
    O_K0    = 6'd9,
    O_K1    = 6'd10,
    O_A     = 6'd11,
    O_C     = 6'd12,
    O_D     = 6'd13,
    O_INN   = 6'd16,
    O_XS    = 6'd17,
    O_XV    = 6'd18,
    O_PS00  = 6'd19,
    O_PS01  = 6'd20,
    O_PS10  = 6'd21,
    O_PS11  = 6'd22,
    O_CUR   = 6'd23,
    O_VOLT  = 6'd24,
    O_ALPHA = 6'd25,
    O_BETA  = 6'd26,
    O_R0    = 6'd27,
    O_CSTEP = 6'd28,
    O_QS    = 6'd29,
    O_QR    = 6'd30,
    O_RM    = 6'd31,
    O_SLOPE = 6'd32,
    O_THREE = 6'd33,
    O_ONE   = 6'd34,
    O_ZERO  = 6'd35
  } opnd_t;

  typedef struct packed {
    alu_op_t op;
    opnd_t   dst;
    opnd_t   a;
    opnd_t   b;
  } uop_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_FETCH = 3'd1,
    ST_EXEC  = 3'd2,
    ST_MUL   = 3'd3,
    ST_DIV   = 3'd4,
    ST_FIN   = 3'd5,
    ST_DONE  = 3'd6
  } seq_state_t;

  localparam int unsigned PC_BITS   = 6;
  localparam logic [PC_BITS-1:0] PROG_LAST = 6'd53;

  // unsigned saturation of an elaboration-time constant to a w-bit signed word
  function automatic logic [127:0] ksat(input logic [127:0] v, input int unsigned w);
    logic [127:0] m;
    m = (128'd1 << (w - 1)) - 128'd1;
    return (v > m) ? m : v;
  endfunction

  // one predict-and-update step, one operation per entry
  function automatic uop_t prog_rom(input logic [PC_BITS-1:0] pc);
    uop_t u;
    u = '{ALU_ADD, O_T0, O_ZERO, O_ZERO};
    unique case (pc)
      // predict soc and rc voltage
      6'd0:  u = '{ALU_MUL,   O_T0,   O_CUR,   O_CSTEP};
      6'd1:  u = '{ALU_SUB,   O_SOCP, O_XS,    O_T0};
      6'd2:  u = '{ALU_CLAMP, O_SOCP, O_SOCP,  O_ZERO};
      6'd3:  u = '{ALU_MUL,   O_T0,   O_ALPHA, O_XV};
      6'd4:  u = '{ALU_MUL,   O_T1,   O_BETA,  O_CUR};
      6'd5:  u = '{ALU_ADD,   O_VRCP, O_T0,    O_T1};
      // predict covariance
      6'd6:  u = '{ALU_ADD,   O_P00,  O_PS00,  O_QS};
      6'd7:  u = '{ALU_MUL,   O_P01,  O_ALPHA, O_PS01};
      6'd8:  u = '{ALU_MUL,   O_P10,  O_ALPHA, O_PS10};
      6'd9:  u = '{ALU_MUL,   O_T0,   O_ALPHA, O_ALPHA};
      6'd10: u = '{ALU_MUL,   O_T0,   O_T0,    O_PS11};
      6'd11: u = '{ALU_ADD,   O_P11,  O_T0,    O_QR};
      // predicted terminal voltage and innovation
      6'd12: u = '{ALU_MUL,   O_T0,   O_SLOPE, O_SOCP};
      6'd13: u = '{ALU_ADD,   O_T0,   O_THREE, O_T0};
      6'd14: u = '{ALU_MUL,   O_T1,   O_CUR,   O_R0};
      6'd15: u = '{ALU_SUB,   O_T0,   O_T0,    O_T1};
      6'd16: u = '{ALU_SUB,   O_T0,   O_T0,    O_VRCP};
      6'd17: u = '{ALU_SUB,   O_INN,  O_VOLT,  O_T0};
      // innovation covariance
      6'd18: u = '{ALU_MUL,   O_T0,   O_SLOPE, O_SLOPE};
      6'd19: u = '{ALU_MUL,   O_S,    O_T0,    O_P00};
      6'd20: u = '{ALU_MUL,   O_T0,   O_SLOPE, O_P01};
      6'd21: u = '{ALU_SUB,   O_S,    O_S,     O_T0};
      6'd22: u = '{ALU_MUL,   O_T0,   O_SLOPE, O_P10};
      6'd23: u = '{ALU_SUB,   O_S,    O_S,     O_T0};
      6'd24: u = '{ALU_ADD,   O_S,    O_S,     O_P11};
      6'd25: u = '{ALU_ADD,   O_S,    O_S,     O_RM};
      // gains
      6'd26: u = '{ALU_MUL,   O_T0,   O_SLOPE, O_P00};
      6'd27: u = '{ALU_SUB,   O_K0,   O_T0,    O_P01};
      6'd28: u = '{ALU_MUL,   O_T0,   O_SLOPE, O_P10};
      6'd29: u = '{ALU_SUB,   O_K1,   O_T0,    O_P11};
      6'd30: u = '{ALU_DIV,   O_K0,   O_K0,    O_S};
      6'd31: u = '{ALU_DIV,   O_K1,   O_K1,    O_S};
      // state correction
      6'd32: u = '{ALU_MUL,   O_T0,   O_K0,    O_INN};
      6'd33: u = '{ALU_ADD,   O_T0,   O_SOCP,  O_T0};
      6'd34: u = '{ALU_CLAMP, O_XS,   O_T0,    O_ZERO};
      6'd35: u = '{ALU_MUL,   O_T0,   O_K1,    O_INN};
      6'd36: u = '{ALU_ADD,   O_XV,   O_VRCP,  O_T0};
      // covariance correction terms
      6'd37: u = '{ALU_MUL,   O_T0,   O_K0,    O_SLOPE};
      6'd38: u = '{ALU_SUB,   O_A,    O_ONE,   O_T0};
      6'd39: u = '{ALU_MUL,   O_T0,   O_K1,    O_SLOPE};
      6'd40: u = '{ALU_SUB,   O_C,    O_ZERO,  O_T0};
      6'd41: u = '{ALU_ADD,   O_D,    O_ONE,   O_K1};
      6'd42: u = '{ALU_MUL,   O_T0,   O_A,     O_P00};
      6'd43: u = '{ALU_MUL,   O_T1,   O_K0,    O_P10};
      6'd44: u = '{ALU_ADD,   O_PS00, O_T0,    O_T1};
      6'd45: u = '{ALU_MUL,   O_T0,   O_A,     O_P01};
      6'd46: u = '{ALU_MUL,   O_T1,   O_K0,    O_P11};
      6'd47: u = '{ALU_ADD,   O_PS01, O_T0,    O_T1};
      6'd48: u = '{ALU_MUL,   O_T0,   O_C,     O_P00};
      6'd49: u = '{ALU_MUL,   O_T1,   O_D,     O_P10};
      6'd50: u = '{ALU_ADD,   O_PS10, O_T0,    O_T1};
      6'd51: u = '{ALU_MUL,   O_T0,   O_C,     O_P01};
      6'd52: u = '{ALU_MUL,   O_T1,   O_D,     O_P11};
      6'd53: u = '{ALU_ADD,   O_PS11, O_T0,    O_T1};
      default: u = '{ALU_ADD, O_T0, O_ZERO, O_ZERO};
    endcase
    return u;
  endfunction

endpackage

// ===== rtl/battery_soc_kalman_filter_top.sv =====
// battery_soc_kalman_filter_top: two-state extended kalman filter for cell soc
// depends on bskf_pkg; one shared bit-serial multiply/divide unit run by a step program
//
//  channel   | signals                          | payload
//  ----------+----------------------------------+------------------------------
//  input     | in_valid / in_ready / in_data    | in_item_t (current, voltage)
//  output    | out_valid / out_ready / out_data | out_item_t (soc, rc v, innov)
//  config    | cfg_en / cfg_index / cfg_data    | raw register value, no wait
//
// one transaction runs 54 operations: 27 multiplies, 2 divides (no serial
// loop when the divisor is zero) and 25 add/sub/clamp steps, between the
// accept and the hand-off; the one-bit-per-cycle multiply and divide
// loops take up most of that time
// rst is synchronous and clears control, configuration registers and filter state
// a new input is taken while a result still waits on the output register

module battery_soc_kalman_filter_top
  import bskf_pkg::*;
#(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_item_t                in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_item_t               out_data,
  input  logic                    cfg_en,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data
);

  localparam int unsigned W     = WORD_BITS;
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned QW    = W + F;
  localparam int unsigned CNT_W = $clog2(QW + 1);

  localparam logic [127:0] WMAX_L  = (128'd1 << (W - 1)) - 128'd1;
  localparam logic [127:0] ONE_L   = ksat(128'd1 << F, W);
  localparam logic [127:0] THREE_L = ksat(128'd3 << F, W);
  localparam logic [127:0] SLOPE_L = ksat(((128'd12 << F) + 128'd5) / 128'd10, W);
  localparam logic [127:0] V01_L   = ksat(((128'd1 << F) + 128'd50) / 128'd100, W);
  localparam logic [127:0] V001_L  = ksat(((128'd1 << F) + 128'd500) / 128'd1000, W);

  localparam logic [W-1:0] WMAX  = WMAX_L[W-1:0];
  localparam logic [W-1:0] WMIN  = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE_V = ONE_L[W-1:0];

  // sequencer
  seq_state_t         state, state_next;
  logic [PC_BITS-1:0] pc;
  uop_t               uop;
  logic               last_op;

  // configuration registers
  logic [32:0] cfg_soc, cfg_cstep, cfg_alpha, cfg_qs, cfg_qr, cfg_rm;
  logic [40:0] cfg_beta, cfg_r0;

  // filter state and captured sample
  logic [W-1:0] xs, xv, ps00, ps01, ps10, ps11, inn, cur, volt;

  // scratch memory, two registered read ports
  logic [W-1:0] mem [0:15];
  logic [W-1:0] rd_a, rd_b;

  // serial unit
  logic [W-1:0]     mx, my, dvs, rem;
  logic [2*W-1:0]   acc;
  logic [QW-1:0]    qsh;
  logic             neg;
  logic [CNT_W-1:0] cnt;

  logic [W-1:0] opa, opb, fa, fb, alu_res, fin_res, wr_val;
  logic         wr_en, accept, done_load;
  logic [W:0]   sum, dif, mstep, r2, rsub;
  logic         ge;

  function automatic logic [W-1:0] usat(input logic [63:0] v);
    if (v > WMAX_L[63:0]) return WMAX;
    return v[W-1:0];
  endfunction

  function automatic logic [W-1:0] from_q16(input logic [31:0] x);
    logic signed [127:0] e;
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    e  = signed'({{96{x[31]}}, x}) <<< (F - 16);
    hi = signed'(WMAX_L);
    lo = -hi - 128'sd1;
    if (e > hi) return WMAX;
    if (e < lo) return WMIN;
    return e[W-1:0];
  endfunction

  function automatic logic [W-1:0] satw(input logic [W:0] s);
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] mag(input logic [W-1:0] a);
    return a[W-1] ? (~a + 1'b1) : a;
  endfunction

  function automatic logic [W-1:0] from_mag(input logic n, input logic [127:0] m);
    if (n) begin
      if (m > WMAX_L) return WMIN;
      return ~m[W-1:0] + 1'b1;
    end
    if (m > WMAX_L) return WMAX;
    return m[W-1:0];
  endfunction

  function automatic logic [W-1:0] flop_val(input opnd_t c);
    logic [W-1:0] v;
    v = '0;
    unique case (c)
      O_INN:   v = inn;
      O_XS:    v = xs;
      O_XV:    v = xv;
      O_PS00:  v = ps00;
      O_PS01:  v = ps01;
      O_PS10:  v = ps10;
      O_PS11:  v = ps11;
      O_CUR:   v = cur;
      O_VOLT:  v = volt;
      O_ALPHA: v = usat({31'd0, cfg_alpha});
      O_BETA:  v = usat({23'd0, cfg_beta});
      O_R0:    v = usat({23'd0, cfg_r0});
      O_CSTEP: v = usat({31'd0, cfg_cstep});
      O_QS:    v = usat({31'd0, cfg_qs});
      O_QR:    v = usat({31'd0, cfg_qr});
      O_RM:    v = usat({31'd0, cfg_rm});
      O_SLOPE: v = SLOPE_L[W-1:0];
      O_THREE: v = THREE_L[W-1:0];
      O_ONE:   v = ONE_V;
      default: v = '0;
    endcase
    return v;
  endfunction

  // operand selection and combinational arithmetic
  always_comb begin
    uop     = prog_rom(pc);
    last_op = (pc == PROG_LAST);
    fa      = flop_val(uop.a);
    fb      = flop_val(uop.b);
    opa     = (uop.a[5:4] == 2'b00) ? rd_a : fa;
    opb     = (uop.b[5:4] == 2'b00) ? rd_b : fb;
    sum     = {opa[W-1], opa} + {opb[W-1], opb};
    dif     = {opa[W-1], opa} - {opb[W-1], opb};
    unique case (uop.op)
      ALU_ADD: alu_res = satw(sum);
      ALU_SUB: alu_res = satw(dif);
      ALU_CLAMP: begin
        if (opa[W-1]) alu_res = '0;
        else if (opa > ONE_V) alu_res = ONE_V;
        else alu_res = opa;
      end
      default: alu_res = '0;
    endcase
    // serial steps
    mstep = {1'b0, acc[2*W-1:W]} + (my[0] ? {1'b0, mx} : {(W+1){1'b0}});
    r2    = {rem, qsh[QW-1]};
    rsub  = r2 - {1'b0, dvs};
    ge    = (r2 >= {1'b0, dvs});
    // final rounding toward zero and saturation
    if (uop.op == ALU_MUL) fin_res = from_mag(neg, 128'(acc >> F));
    else fin_res = from_mag(neg, 128'(qsh));
  end

  // sequencer next state and handshakes
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    wr_en      = 1'b0;
    wr_val     = alu_res;
    done_load  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = ST_FETCH;
      end
      ST_FETCH: state_next = ST_EXEC;
      ST_EXEC: begin
        if (uop.op == ALU_MUL) begin
          state_next = ST_MUL;
        end else if (uop.op == ALU_DIV && opb != '0) begin
          state_next = ST_DIV;
        end else begin
          wr_en      = 1'b1;
          state_next = last_op ? ST_DONE : ST_FETCH;
        end
      end
      ST_MUL: if (cnt == CNT_W'(W - 1)) state_next = ST_FIN;
      ST_DIV: if (cnt == CNT_W'(QW - 1)) state_next = ST_FIN;
      ST_FIN: begin
        wr_en      = 1'b1;
        wr_val     = fin_res;
        state_next = last_op ? ST_DONE : ST_FETCH;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          done_load  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    accept = in_ready && in_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // program counter
  always_ff @(posedge clk) begin
    if (rst) pc <= '0;
    else if (accept) pc <= '0;
    else if (wr_en && !last_op) pc <= pc + 1'b1;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_soc <= '0; cfg_cstep <= '0; cfg_alpha <= '0; cfg_beta <= '0;
      cfg_r0  <= '0; cfg_qs    <= '0; cfg_qr    <= '0; cfg_rm   <= '0;
    end else if (cfg_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_INITIAL_SOC:       cfg_soc   <= cfg_data[32:0];
        REG_CHARGE_STEP:       cfg_cstep <= cfg_data[32:0];
        REG_DECAY_FACTOR:      cfg_alpha <= cfg_data[32:0];
        REG_RC_GAIN:           cfg_beta  <= cfg_data;
        REG_SERIES_RESISTANCE: cfg_r0    <= cfg_data;
        REG_SOC_PROCESS_NOISE: cfg_qs    <= cfg_data[32:0];
        REG_RC_PROCESS_NOISE:  cfg_qr    <= cfg_data[32:0];
        REG_MEASUREMENT_NOISE: cfg_rm    <= cfg_data[32:0];
        default: ;
      endcase
    end
  end

  // filter state: reset, reinit on initial soc write, program writes
  always_ff @(posedge clk) begin
    if (rst) begin
      xs <= '0; xv <= '0; ps00 <= V01_L[W-1:0]; ps01 <= '0; ps10 <= '0;
      ps11 <= V001_L[W-1:0];
    end else if (cfg_en && cfg_reg_t'(cfg_index) == REG_INITIAL_SOC) begin
      xs <= usat({31'd0, cfg_data[32:0]}); xv <= '0; ps00 <= V01_L[W-1:0];
      ps01 <= '0; ps10 <= '0; ps11 <= V001_L[W-1:0];
    end else if (wr_en) begin
      unique case (uop.dst)
        O_XS:    xs   <= wr_val;
        O_XV:    xv   <= wr_val;
        O_PS00:  ps00 <= wr_val;
        O_PS01:  ps01 <= wr_val;
        O_PS10:  ps10 <= wr_val;
        O_PS11:  ps11 <= wr_val;
        default: ;
      endcase
    end
  end

  // sample capture and innovation
  always_ff @(posedge clk) begin
    if (accept) begin
      cur  <= from_q16(in_data.cell_current);
      volt <= from_q16(in_data.cell_voltage);
    end
    if (wr_en && uop.dst == O_INN) inn <= wr_val;
  end

  // scratch memory
  always_ff @(posedge clk) begin
    if (wr_en && uop.dst[5:4] == 2'b00) mem[uop.dst[3:0]] <= wr_val;
    rd_a <= mem[uop.a[3:0]];
    rd_b <= mem[uop.b[3:0]];
  end

  // bit-serial multiply and restoring divide
  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      neg <= opa[W-1] ^ opb[W-1];
      cnt <= '0;
      mx  <= mag(opa);
      my  <= mag(opb);
      acc <= '0;
      dvs <= mag(opb);
      rem <= '0;
      qsh <= {mag(opa), {F{1'b0}}};
    end else if (state == ST_MUL) begin
      acc <= {mstep, acc[W-1:1]};
      my  <= my >> 1;
      cnt <= cnt + 1'b1;
    end else if (state == ST_DIV) begin
      rem <= ge ? rsub[W-1:0] : r2[W-1:0];
      qsh <= {qsh[QW-2:0], ge};
      cnt <= cnt + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (done_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (done_load) begin
      out_data.soc_estimate <= 33'({{(64-W){xs[W-1]}}, xs});
      out_data.rc_voltage   <= 48'({{(64-W){xv[W-1]}}, xv});
      out_data.innovation   <= 48'({{(64-W){inn[W-1]}}, inn});
    end
  end

endmodule

// ===== rtl/bskf_checker.sv =====
// bskf_checker: port-level checks on the soc kalman filter top level
// no package dependency; bound to battery_soc_kalman_filter_top below
module bskf_checker (
  input logic         clk,
  input logic         rst,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [128:0] out_data
);

  // a waiting result is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // one transaction at a time: busy after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a step runs");

endmodule

bind battery_soc_kalman_filter_top bskf_checker u_bskf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
